// ----- hdl/dms_pkg.sv -----
// Shared types and constants for the descending merge sorter.
`default_nettype none
package dms_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         final_res;
    logic                         overflow;
  } out_t;

  typedef struct packed {
    logic                         ins;
    logic                         shl;
    logic signed [ValueWidth-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/dms_cell.sv -----
// One cell of the sorting chain: holds one element and its valid bit.
`default_nettype none
module dms_cell
  import dms_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cell_ctrl_t                   ctrl,
  input  wire logic signed [ValueWidth-1:0] left_val,
  input  wire logic                         left_valid,
  input  wire logic                         left_disp,
  input  wire logic signed [ValueWidth-1:0] right_val,
  input  wire logic                         right_valid,
  output logic signed [ValueWidth-1:0]      val,
  output logic                              valid,
  output logic                              disp
);

  logic signed [ValueWidth-1:0] val_r;
  logic signed [ValueWidth-1:0] val_nxt;
  logic                         valid_r;
  logic                         valid_nxt;

  // An element is displaced by a strictly larger newcomer, so equal values keep arrival order.
  assign disp = !valid_r || ($signed(val_r) < $signed(ctrl.value));

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.shl) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (ctrl.ins) begin
      if (left_disp) begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end else if (disp) begin
        val_nxt   = ctrl.value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

// ----- hdl/descending_merge_sorter.sv -----
// Top level of the descending sorter: a chain of insertion cells with a result register.
//
// Values arrive on the in_ channel (valid/ready), one transaction per cycle while
// in_ready is high. Each value is inserted into a chain of DEPTH cells in the
// cycle it is accepted, so the chain always holds the set in descending order,
// equal values in arrival order. Values beyond DEPTH are dropped and the set is
// marked as overflowed. The transaction carrying last ends the set: in_ready then
// falls and the chain shifts its contents towards the result register, one
// element per cycle while the receiver takes them, with final_res on the last
// one. A new set is not accepted until the previous one has drained: in_ready
// rises again as the final result enters the result register. When the receiver
// stalls, the result register holds its transaction and the chain waits. Reset
// empties the chain and clears the overflow mark; stored values themselves are
// not cleared.
`default_nettype none
module descending_merge_sorter
  import dms_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  state_t     state_r;
  state_t     state_nxt;
  logic       drop_r;
  logic       drop_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_t       out_data_r;
  logic       in_acc;
  logic       full;
  logic       load_out;
  logic       is_final;
  cell_ctrl_t ctrl;

  logic signed [ValueWidth-1:0] val_w   [DEPTH];
  logic                         valid_w [DEPTH];
  logic                         disp_w  [DEPTH];

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = valid_w[DEPTH-1];
  assign load_out = (state_r == ST_DRAIN) && valid_w[0] && (!out_valid_r || out_ready);
  assign is_final = !valid_w[1];

  always_comb begin
    ctrl.ins   = in_acc && !full;
    ctrl.shl   = load_out;
    ctrl.value = in_data.value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueWidth-1:0] lv;
    logic                         lvalid;
    logic                         ldisp;
    logic signed [ValueWidth-1:0] rv;
    logic                         rvalid;

    if (i == 0) begin : g_first
      assign lv     = '0;
      assign lvalid = 1'b0;
      assign ldisp  = 1'b0;
    end else begin : g_mid
      assign lv     = val_w[i-1];
      assign lvalid = valid_w[i-1];
      assign ldisp  = disp_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_body
      assign rv     = val_w[i+1];
      assign rvalid = valid_w[i+1];
    end

    dms_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_val    (lv),
      .left_valid  (lvalid),
      .left_disp   (ldisp),
      .right_val   (rv),
      .right_valid (rvalid),
      .val         (val_w[i]),
      .valid       (valid_w[i]),
      .disp        (disp_w[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end
          if (in_data.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (is_final) begin
            state_nxt = ST_LOAD;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.sorted_value <= val_w[0];
      out_data_r.final_res    <= is_final;
      out_data_r.overflow     <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hdl/dms_checker.sv -----
// Port-level checker for the descending sorter, bound to the top level.
`default_nettype none
module dms_checker
  import dms_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or vanished.");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("Input still accepted after the end of a set.");

  a_set_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.final_res |=> out_valid)
    else $error("Result channel went idle before the final result of a set.");

  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && $past(!in_ready) |-> out_valid)
    else $error("Result channel idle while a set is being emitted.");

endmodule

bind descending_merge_sorter dms_checker u_dms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
